### hdl/sfc_pkg.sv
// ---------------------------------------------------------------------------
// sfc_pkg: shared types and constants for the floor/ceiling search core
// Holds field widths, command codes and the structs that pass between the
// top level and the search engine.
// ---------------------------------------------------------------------------
package sfc_pkg;

  localparam int VALUE_W     = 32;
  localparam int LEN_W       = 11;
  localparam int ENTRY_IDX_W = 10;

  // Command codes of an input word
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] floor_value;
    logic                      floor_found;
    logic signed [VALUE_W-1:0] ceil_value;
    logic                      ceil_found;
  } sfc_result_t;

  // Engine status seen by the top level
  typedef struct packed {
    logic idle;
    logic res_valid;
  } sfc_stat_t;

endpackage

### hdl/sfc_search_engine.sv
// ---------------------------------------------------------------------------
// sfc_search_engine: table memory and interleaved binary search sequencer
// Owns the table memory and one signed comparator. The floor and ceiling
// searches take turns on the single read port, one probe issued per cycle while both searches are active.
// ---------------------------------------------------------------------------
module sfc_search_engine
  import sfc_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [ENTRY_IDX_W-1:0]    wr_index,
  input  logic signed [VALUE_W-1:0] wr_data,
  input  logic                      start,
  input  logic signed [VALUE_W-1:0] key,
  input  logic [LEN_W-1:0]          table_length,
  input  logic                      res_ready,
  output sfc_stat_t                 stat,
  output sfc_result_t               res
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW    = IDX_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  localparam logic SIDE_FLOOR = 1'b0;
  localparam logic SIDE_CEIL  = 1'b1;

  logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;

  state_t                    state_r, state_nxt;
  logic signed [SW-1:0]      f_lo_r, f_lo_nxt, f_hi_r, f_hi_nxt;
  logic signed [SW-1:0]      c_lo_r, c_lo_nxt, c_hi_r, c_hi_nxt;
  logic                      pend_r, pend_nxt;
  logic                      pend_side_r, pend_side_nxt;
  logic signed [SW-1:0]      pend_mid_r, pend_mid_nxt;
  logic signed [VALUE_W-1:0] key_r;
  sfc_result_t               res_r, res_nxt;

  logic                      f_act, c_act, can_f, can_c, issue, issue_side;
  logic signed [SW-1:0]      sel_lo, sel_hi, mid;
  logic [SW-1:0]             mid_sum;
  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W-1:0]          wr_addr;
  logic [31:0]               wr_ext, len_ext, len_clamp;
  logic signed [SW-1:0]      hi_init;
  logic signed [VALUE_W-1:0] cmp_a, cmp_b;
  logic                      hit, move_lo;

  assign f_act = (f_lo_r <= f_hi_r);
  assign c_act = (c_lo_r <= c_hi_r);
  assign can_f = f_act && !(pend_r && (pend_side_r == SIDE_FLOOR));
  assign can_c = c_act && !(pend_r && (pend_side_r == SIDE_CEIL));

  // Prefer floor; a pending floor read blocks it, so the two sides alternate
  assign issue_side = can_f ? SIDE_FLOOR : SIDE_CEIL;
  assign issue      = (state_r == ST_RUN) && (can_f || can_c);
  assign sel_lo     = (issue_side == SIDE_FLOOR) ? f_lo_r : c_lo_r;
  assign sel_hi     = (issue_side == SIDE_FLOOR) ? f_hi_r : c_hi_r;
  assign mid_sum    = SW'(sel_lo) + SW'(sel_hi);
  assign mid        = $signed(mid_sum >> 1);
  assign rd_addr    = mid[IDX_W-1:0];

  assign wr_ext  = 32'(wr_index);
  assign wr_addr = wr_ext[IDX_W-1:0];

  assign len_ext   = 32'(table_length);
  assign len_clamp = (len_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : len_ext;
  assign hi_init   = $signed(len_clamp[SW-1:0]) - SW'(1);

  // Shared comparator: floor asks entry <= key, ceiling asks key <= entry
  assign cmp_a   = (pend_side_r == SIDE_CEIL) ? key_r : rd_data_r;
  assign cmp_b   = (pend_side_r == SIDE_CEIL) ? rd_data_r : key_r;
  assign hit     = (cmp_a <= cmp_b);
  assign move_lo = hit ^ (pend_side_r == SIDE_CEIL);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    f_lo_nxt      = f_lo_r;
    f_hi_nxt      = f_hi_r;
    c_lo_nxt      = c_lo_r;
    c_hi_nxt      = c_hi_r;
    pend_nxt      = issue;
    pend_side_nxt = issue ? issue_side : pend_side_r;
    pend_mid_nxt  = issue ? mid : pend_mid_r;
    res_nxt       = res_r;
    unique case (state_r)
      ST_IDLE: begin
        pend_nxt = 1'b0;
        if (start) begin
          f_lo_nxt  = '0;
          c_lo_nxt  = '0;
          f_hi_nxt  = hi_init;
          c_hi_nxt  = hi_init;
          res_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // Retire the probe read last cycle
        if (pend_r) begin
          if (hit) begin
            if (pend_side_r == SIDE_FLOOR) begin
              res_nxt.floor_value = rd_data_r;
              res_nxt.floor_found = 1'b1;
            end else begin
              res_nxt.ceil_value = rd_data_r;
              res_nxt.ceil_found = 1'b1;
            end
          end
          if (pend_side_r == SIDE_FLOOR) begin
            if (move_lo) f_lo_nxt = pend_mid_r + SW'(1);
            else         f_hi_nxt = pend_mid_r - SW'(1);
          end else begin
            if (move_lo) c_lo_nxt = pend_mid_r + SW'(1);
            else         c_hi_nxt = pend_mid_r - SW'(1);
          end
        end else if (!f_act && !c_act) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        pend_nxt = 1'b0;
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_lo_r      <= f_lo_nxt;
    f_hi_r      <= f_hi_nxt;
    c_lo_r      <= c_lo_nxt;
    c_hi_r      <= c_hi_nxt;
    pend_side_r <= pend_side_nxt;
    pend_mid_r  <= pend_mid_nxt;
    res_r       <= res_nxt;
    if (start && (state_r == ST_IDLE)) begin
      key_r <= key;
    end
  end

  assign stat.idle      = (state_r == ST_IDLE);
  assign stat.res_valid = (state_r == ST_HOLD);
  assign res            = res_r;

endmodule

### hdl/sorted_table_floor_ceil_search_core.sv
// ---------------------------------------------------------------------------
// sorted_table_floor_ceil_search_core: floor and ceiling lookup in a table
// Holds a table of signed 32-bit entries and answers floor/ceiling queries
// by two binary searches that share one memory read port and one comparator.
// ---------------------------------------------------------------------------
// Software loads the table in ascending order, one load word per entry, and
// sets cfg_table_length to the number of entries in use from index zero
// (values above TABLE_DEPTH act as TABLE_DEPTH). A load word produces nothing;
// a load at an index at or above TABLE_DEPTH is dropped. A query word returns
// one result word: the floor (largest entry not above the key) and the
// ceiling (smallest entry not below the key), each with a found flag; a value
// whose flag is clear reads zero. Each probe costs one read of the single
// table port, and the floor and ceiling probes alternate on that port, so one
// probe retires per cycle while both searches are still active. The input is
// not ready while a query is in flight. A finished result waits in an output
// register, so the next word is taken while the previous result is still
// waiting. Entries in use must have been loaded; the table has no reset
// value. Write the length register only while the core is idle.
// ---------------------------------------------------------------------------
module sorted_table_floor_ceil_search_core
  import sfc_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [LEN_W-1:0]          cfg_table_length,
  // input word channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [ENTRY_IDX_W-1:0]    in_entry_index,
  input  logic signed [VALUE_W-1:0] in_entry_value,
  input  logic signed [VALUE_W-1:0] in_search_key,
  // result word channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_floor_value,
  output logic                      out_floor_found,
  output logic signed [VALUE_W-1:0] out_ceil_value,
  output logic                      out_ceil_found
);

  logic [LEN_W-1:0] table_length_r;
  logic             out_valid_r, out_valid_nxt;
  sfc_result_t      out_res_r;

  logic             in_fire, load_fire, query_fire, wr_en, res_ready, res_take;
  sfc_stat_t        stat;
  sfc_result_t      res;

  // Length register: always writable, the user keeps writes to idle time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      table_length_r <= cfg_table_length;
    end
  end

  // Accept words only while the engine is idle
  assign in_ready   = stat.idle;
  assign in_fire    = in_valid && in_ready;
  assign load_fire  = in_fire && (in_command == CMD_LOAD);
  assign query_fire = in_fire && (in_command == CMD_QUERY);

  // Drop loads that fall outside the table
  assign wr_en = load_fire && (32'(in_entry_index) < 32'(TABLE_DEPTH));

  sfc_search_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (wr_en),
    .wr_index    (in_entry_index),
    .wr_data     (in_entry_value),
    .start       (query_fire),
    .key         (in_search_key),
    .table_length(table_length_r),
    .res_ready   (res_ready),
    .stat        (stat),
    .res         (res)
  );

  // Output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;
  assign res_take  = stat.res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_floor_value = out_res_r.floor_value;
  assign out_floor_found = out_res_r.floor_found;
  assign out_ceil_value  = out_res_r.ceil_value;
  assign out_ceil_found  = out_res_r.ceil_found;

  // A query keeps the input closed on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    query_fire |=> !in_ready)
    else $error("input ready right after a query was accepted");

  // The engine never holds a result while it also claims to be idle
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.res_valid)
    else $error("engine idle while holding a result");

  // A missing floor or ceiling reads as zero
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_floor_found || !out_ceil_found) |->
      ((out_floor_found || (out_floor_value == '0)) &&
       (out_ceil_found || (out_ceil_value == '0))))
    else $error("value of a missing answer is not zero");

  // A load never starts a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> !stat.res_valid)
    else $error("result raised by a load word");

endmodule

### sim/sorted_table_floor_ceil_search_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sorted_table_floor_ceil_search_core_tb: self-checking bench for the core
// Loads sorted, duplicated and unordered tables, sweeps the length register
// from empty to beyond the table depth, and checks each floor/ceiling answer
// against a behavioral binary search kept in step with the loads, or against
// the typed answer of a directed query.
module sorted_table_floor_ceil_search_core_tb;
  import sfc_pkg::*;

  localparam int TABLE_DEPTH    = 1024;
  localparam int RANDOM_WORDS   = 550;   // small-table phases stop near here
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [VALUE_W-1:0] MIN_S32 = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] MAX_S32 = 32'sh7FFF_FFFF;

  localparam sfc_result_t ZERO_ANSWER = '0;
  localparam sfc_result_t MIN_ANSWER  = '{MIN_S32, 1'b1, MIN_S32, 1'b1};
  localparam sfc_result_t MAX_ANSWER  = '{MAX_S32, 1'b1, MAX_S32, 1'b1};

  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_LENGTH} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [ENTRY_IDX_W-1:0]    index;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] key;
    logic [LEN_W-1:0]          length;
    logic                      typed;   // answer column holds the expected word
    sfc_result_t               answer;
  } stim_row_t;

  // Directed opening: empty table, field extremes, exact hits, misses on both
  // sides, a one-entry table, an unordered table and a return to empty.
  // Queries carry junk in the load fields and loads junk in the key.
  stim_row_t directed_rows [26] = '{
    '{ROW_QUERY,  10'h3FF, MAX_S32,   MIN_S32,  11'd0, 1'b1, ZERO_ANSWER},
    '{ROW_QUERY,  10'h155, MIN_S32,   MAX_S32,  11'd0, 1'b1, ZERO_ANSWER},
    '{ROW_QUERY,  10'h000, 32'sd0,    32'sd0,   11'd0, 1'b1, ZERO_ANSWER},
    '{ROW_LOAD,   10'd0,   MIN_S32,   MAX_S32,  11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LOAD,   10'd1,   -32'sd5,   -32'sd1,  11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LOAD,   10'd2,   32'sd0,    MIN_S32,  11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LOAD,   10'd3,   32'sd7,    32'sd0,   11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LOAD,   10'd4,   MAX_S32,   32'sd9,   11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LOAD,   10'h3FF, MAX_S32,   -32'sd1,  11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LENGTH, 10'd0,   32'sd0,    32'sd0,   11'd5, 1'b0, ZERO_ANSWER},
    '{ROW_QUERY,  10'h2AA, -32'sd1,   MIN_S32,  11'd0, 1'b1, MIN_ANSWER},
    '{ROW_QUERY,  10'h3FF, MIN_S32,   MAX_S32,  11'd0, 1'b1, MAX_ANSWER},
    '{ROW_QUERY,  10'd3,   32'sd1,    32'sd6,   11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_QUERY,  10'd1,   32'sd0,    -32'sd5,  11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_QUERY,  10'd2,   32'sd0,    32'sd0,   11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_QUERY,  10'd0,   32'sd0,    -32'sd6,  11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LENGTH, 10'd0,   32'sd0,    32'sd0,   11'd1, 1'b0, ZERO_ANSWER},
    '{ROW_QUERY,  10'd0,   32'sd0,    -32'sd1,  11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_QUERY,  10'd0,   32'sd0,    MIN_S32,  11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LOAD,   10'd1,   32'sd100,  32'sd0,   11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LOAD,   10'd0,   32'sd50,   32'sd0,   11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LENGTH, 10'd0,   32'sd0,    32'sd0,   11'd3, 1'b0, ZERO_ANSWER},
    '{ROW_QUERY,  10'd0,   32'sd0,    32'sd60,  11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_QUERY,  10'd0,   32'sd0,    32'sd0,   11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_LENGTH, 10'd0,   32'sd0,    32'sd0,   11'd0, 1'b0, ZERO_ANSWER},
    '{ROW_QUERY,  10'd0,   32'sd0,    32'sd7,   11'd0, 1'b1, ZERO_ANSWER}
  };

  // DUT ports; every input is known from time zero
  logic                      clk;
  logic                      rst_n            = 1'b0;
  logic                      cfg_valid        = 1'b0;
  logic                      cfg_ready;
  logic [LEN_W-1:0]          cfg_table_length = '0;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic                      in_command       = CMD_LOAD;
  logic [ENTRY_IDX_W-1:0]    in_entry_index   = '0;
  logic signed [VALUE_W-1:0] in_entry_value   = '0;
  logic signed [VALUE_W-1:0] in_search_key    = '0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  logic signed [VALUE_W-1:0] out_floor_value;
  logic                      out_floor_found;
  logic signed [VALUE_W-1:0] out_ceil_value;
  logic                      out_ceil_found;

  // Sideband that travels with a directed query: use the typed answer
  logic        typed_valid  = 1'b0;
  sfc_result_t typed_answer = '0;

  // Shadow of the core's table and length register, updated on handshakes
  logic signed [VALUE_W-1:0] table_shadow [TABLE_DEPTH];
  logic [LEN_W-1:0]          length_shadow = '0;
  sfc_result_t               pending_answers [$];

  int       mismatch_count = 0;
  int       quiet_cycles   = 0;
  int       words_sent     = 0;
  int       burst_left     = 0;
  bit       steady_sender  = 1'b0;
  int       stall_left     = 0;
  rx_mode_t stall_mode     = RX_OPEN;

  sorted_table_floor_ceil_search_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_table_length (cfg_table_length),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_search_key    (in_search_key),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_floor_value  (out_floor_value),
    .out_floor_found  (out_floor_found),
    .out_ceil_value   (out_ceil_value),
    .out_ceil_found   (out_ceil_found)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Floor/ceiling prediction: two binary searches with the midpoint rounded
  // down, recording whatever the probes meet. On an unordered table this is
  // what the hardware must report, not the true floor and ceiling.
  // -------------------------------------------------------------------------
  function automatic sfc_result_t floor_ceil_of(input logic signed [VALUE_W-1:0] key);
    sfc_result_t answer;
    int          span;
    int          lo;
    int          hi;
    int          mid;
    answer = '0;
    // Clamp lengths above the depth to the depth
    span = (length_shadow > LEN_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(length_shadow);
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (table_shadow[mid] <= key) begin
        answer.floor_value = table_shadow[mid];
        answer.floor_found = 1'b1;
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key <= table_shadow[mid]) begin
        answer.ceil_value = table_shadow[mid];
        answer.ceil_found = 1'b1;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return answer;
  endfunction

  task automatic report_mismatch(input string what, input sfc_result_t want,
                                 input sfc_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected floor %0d/%0b ceil %0d/%0b, got floor %0d/%0b ceil %0d/%0b",
               $time, what, want.floor_value, want.floor_found, want.ceil_value,
               want.ceil_found, got.floor_value, got.floor_found, got.ceil_value,
               got.ceil_found);
  endtask

  // -------------------------------------------------------------------------
  // Sender. Words go out in bursts; between bursts valid drops for a random
  // gap, short most of the time and now and then long enough to span a whole
  // query. In a steady phase the gaps vanish. Valid is only raised here and
  // only lowered before a gap or a drain, never twice in one step.
  // -------------------------------------------------------------------------
  task automatic send_word(input logic cmd, input logic [ENTRY_IDX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] value,
                           input logic signed [VALUE_W-1:0] key,
                           input logic typed, input sfc_result_t answer);
    int gap;
    if (burst_left == 0) begin
      if (steady_sender)
        gap = 0;
      else if ($urandom_range(0, 3) == 0)
        gap = $urandom_range(7, 30);
      else
        gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= idx;
    in_entry_value <= value;
    in_search_key  <= key;
    typed_valid    <= typed;
    typed_answer   <= answer;
    // Hold the word until the core takes it
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Drop valid and wait until every expected answer has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  // Write the length only with the core idle: drained, then a settle time
  // long enough for any search still in flight
  task automatic set_length(input logic [LEN_W-1:0] len);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_table_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Load entries 0..count-1 in index order. Most tables are ascending, built
  // from a running level: dense steps give runs of duplicates, wide steps
  // spread the entries over the whole signed range. One in ten is unordered.
  task automatic load_table(input int count);
    int                        style;
    longint                    level;
    longint                    stride;
    logic signed [VALUE_W-1:0] entry;
    style = $urandom_range(0, 9);
    if (style <= 2)
      stride = 2;
    else if (style <= 5)
      stride = 5000;
    else
      stride = 64'h1_0000_0000 / (count + 1);
    if (style >= 6 || $urandom_range(0, 9) == 0)
      level = longint'(MIN_S32) + longint'($urandom_range(0, 32'(stride)));
    else
      level = int'($urandom());
    for (int i = 0; i < count; i++) begin
      if (style == 9) begin
        entry = $urandom();
      end else begin
        if (level > longint'(MAX_S32))
          level = longint'(MAX_S32);
        entry = level[VALUE_W-1:0];
        level += longint'($urandom_range(0, 32'(stride)));
      end
      send_word(CMD_LOAD, ENTRY_IDX_W'(i), entry, $urandom(), 1'b0, ZERO_ANSWER);
    end
  endtask

  // Query burst against the current table. Keys aim at entries, just below
  // and just above them, the extremes and zero, or anywhere. A few stray
  // loads land in between, and now and then the sender waits for all answers.
  task automatic run_queries(input int count);
    int                        sel;
    int                        span;
    logic signed [VALUE_W-1:0] probe;
    logic signed [VALUE_W-1:0] key;
    for (int q = 0; q < count; q++) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_word(CMD_LOAD, ENTRY_IDX_W'($urandom()), $urandom(), $urandom(), 1'b0,
                  ZERO_ANSWER);
      end else begin
        if (sel < 14)
          drain_results();
        span = (length_shadow > LEN_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(length_shadow);
        sel = $urandom_range(0, 99);
        probe = (span == 0) ? 32'sd0 : table_shadow[$urandom_range(0, span - 1)];
        if (span == 0 || sel < 20)
          key = $urandom();
        else if (sel < 55)
          key = probe;
        else if (sel < 75)
          key = probe - 32'sd1;
        else if (sel < 90)
          key = probe + 32'sd1;
        else if (sel < 94)
          key = MIN_S32;
        else if (sel < 98)
          key = MAX_S32;
        else
          key = 32'sd0;
        send_word(CMD_QUERY, ENTRY_IDX_W'($urandom()), $urandom(), key, 1'b0, ZERO_ANSWER);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    int n;
    int sel;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_LENGTH: begin
          set_length(directed_rows[r].length);
        end
        ROW_LOAD: begin
          send_word(CMD_LOAD, directed_rows[r].index, directed_rows[r].value,
                    directed_rows[r].key, 1'b0, ZERO_ANSWER);
        end
        default: begin
          send_word(CMD_QUERY, directed_rows[r].index, directed_rows[r].value,
                    directed_rows[r].key, directed_rows[r].typed, directed_rows[r].answer);
        end
      endcase
    end

    // Full-depth fill: searches over every entry, then lengths past the depth,
    // which must act as the depth. This also leaves every entry written, so
    // later phases may pick any length without touching unloaded entries.
    load_table(TABLE_DEPTH);
    set_length(LEN_W'(TABLE_DEPTH));
    run_queries(20);
    set_length({LEN_W{1'b1}});
    run_queries(16);
    set_length(LEN_W'(TABLE_DEPTH + 1));
    run_queries(8);

    // Random phases on small tables: reload, set the length, query
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      steady_sender = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 6)
        n = 0;
      else if (sel < 70)
        n = $urandom_range(1, 16);
      else if (sel < 95)
        n = $urandom_range(17, 64);
      else
        n = $urandom_range(65, 256);
      if ($urandom_range(0, 19) == 0) begin
        // Stale contents under an arbitrary length
        set_length(LEN_W'($urandom_range(0, 2047)));
      end else begin
        load_table(n);
        set_length(LEN_W'(n));
      end
      run_queries($urandom_range(6, 24));
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: ready follows a randomly drawn mode, redrawn when its run ends:
  // always open, coin toss, sparse, or long stalls with short open windows.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 80);
    end
    stall_left--;
    case (stall_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ready <= (stall_left % 4 == 0);
      default:   out_ready <= (stall_left % 24 >= 20);
    endcase
  end

  // -------------------------------------------------------------------------
  // Monitor: check result words first, then advance the shadow state with
  // whatever the core accepted at this edge. A result can never belong to a
  // query taken at the same edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    sfc_result_t got;
    sfc_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.floor_value = out_floor_value;
        got.floor_found = out_floor_found;
        got.ceil_value  = out_ceil_value;
        got.ceil_found  = out_ceil_found;
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected result word", ZERO_ANSWER, got);
        end else begin
          want = pending_answers.pop_front();
          if (got.floor_value !== want.floor_value || got.floor_found !== want.floor_found ||
              got.ceil_value !== want.ceil_value || got.ceil_found !== want.ceil_found)
            report_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_LOAD) begin
          if (int'(in_entry_index) < TABLE_DEPTH)
            table_shadow[in_entry_index] = in_entry_value;
        end else begin
          pending_answers.push_back(typed_valid ? typed_answer : floor_ceil_of(in_search_key));
        end
      end
      if (cfg_valid && cfg_ready)
        length_shadow = cfg_table_length;
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
